/* rtl/bacf_pkg.sv */
`default_nettype none

package bacf_pkg;

  typedef enum logic [4:0] {
    OP_ADD     = 5'd0,
    OP_ADC     = 5'd1,
    OP_SUB     = 5'd2,
    OP_SBC     = 5'd3,
    OP_AND     = 5'd4,
    OP_XOR     = 5'd5,
    OP_OR      = 5'd6,
    OP_CP      = 5'd7,
    OP_INC     = 5'd8,
    OP_DEC     = 5'd9,
    OP_RLCA    = 5'd10,
    OP_RRCA    = 5'd11,
    OP_RLA     = 5'd12,
    OP_RRA     = 5'd13,
    OP_DAA     = 5'd14,
    OP_CPL     = 5'd15,
    OP_SCF     = 5'd16,
    OP_CCF     = 5'd17,
    OP_RLC     = 5'd18,
    OP_RRC     = 5'd19,
    OP_RL      = 5'd20,
    OP_RR      = 5'd21,
    OP_SLA     = 5'd22,
    OP_SRA     = 5'd23,
    OP_SWAP    = 5'd24,
    OP_SRL     = 5'd25,
    OP_BIT     = 5'd26,
    OP_RES     = 5'd27,
    OP_SET     = 5'd28,
    OP_ADD16   = 5'd29,
    OP_ADD_SP  = 5'd30
  } op_t;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [4:0]  operation;
    logic [7:0]  operand_a;
    logic [7:0]  operand_b;
    logic [15:0] wide_a;
    logic [15:0] wide_b;
    logic [2:0]  bit_index;
    flags_t      flags;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] result;
    logic        written;
    flags_t      flags;
  } alu_res_t;

  localparam logic [7:0] DaaLowAdjust  = 8'h06;
  localparam logic [7:0] DaaHighAdjust = 8'h60;
  localparam logic [9:0] DaaHighLimit  = 10'h09F;
  localparam logic [3:0] DaaDigitMax   = 4'd9;

endpackage

`default_nettype wire

/* rtl/bacf_alu.sv */
`default_nettype none

module bacf_alu
  import bacf_pkg::*;
(
  input  wire alu_req_t req,
  output alu_res_t      res
);

  logic [7:0]  a;
  logic [7:0]  b;
  flags_t      f;
  logic        cin;
  logic [8:0]  add_sum;
  logic [4:0]  add_half;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_half;
  logic        use_carry_add;
  logic        use_carry_sub;
  logic [7:0]  inc_val;
  logic [7:0]  dec_val;
  logic [9:0]  daa_up1;
  logic [9:0]  daa_up2;
  logic [7:0]  daa_dn;
  logic [7:0]  daa_val;
  logic        daa_carry;
  logic [16:0] w_sum;
  logic [12:0] w_half;
  logic [15:0] sp_sum;
  logic [4:0]  sp_half;
  logic [8:0]  sp_low;
  logic [7:0]  bit_mask;
  logic [7:0]  r8;
  op_t         op;

  assign a   = req.operand_a;
  assign b   = req.operand_b;
  assign f   = req.flags;
  assign cin = f.c;
  assign op  = op_t'(req.operation);

  assign use_carry_add = (op == OP_ADC) && cin;
  assign use_carry_sub = (op == OP_SBC) && cin;

  assign add_sum  = {1'b0, a} + {1'b0, b} + {8'd0, use_carry_add};
  assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, use_carry_add};
  assign sub_diff = {1'b0, a} - {1'b0, b} - {8'd0, use_carry_sub};
  assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, use_carry_sub};

  assign inc_val = a + 8'd1;
  assign dec_val = a - 8'd1;

  // decimal adjust after add or subtract
  assign daa_up1 = (f.h || (a[3:0] > DaaDigitMax)) ? ({2'b00, a} + {2'b00, DaaLowAdjust})
                                                   : {2'b00, a};
  assign daa_up2 = (f.c || (daa_up1 > DaaHighLimit)) ? (daa_up1 + {2'b00, DaaHighAdjust})
                                                     : daa_up1;
  assign daa_dn  = a - (f.h ? DaaLowAdjust : 8'd0) - (f.c ? DaaHighAdjust : 8'd0);
  assign daa_val   = f.n ? daa_dn : daa_up2[7:0];
  assign daa_carry = f.n ? f.c : (f.c || daa_up2[8]);

  assign w_sum  = {1'b0, req.wide_a} + {1'b0, req.wide_b};
  assign w_half = {1'b0, req.wide_a[11:0]} + {1'b0, req.wide_b[11:0]};

  assign sp_sum  = req.wide_a + {{8{b[7]}}, b};
  assign sp_half = {1'b0, req.wide_a[3:0]} + {1'b0, b[3:0]};
  assign sp_low  = {1'b0, req.wide_a[7:0]} + {1'b0, b};

  assign bit_mask = 8'd1 << req.bit_index;

  always_comb begin
    r8          = 8'd0;
    res.result  = 16'd0;
    res.written = 1'b1;
    res.flags   = f;
    case (op)
      OP_ADD, OP_ADC: begin
        r8        = add_sum[7:0];
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: add_half[4], c: add_sum[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r8        = sub_diff[7:0];
        res.flags = '{z: (r8 == 8'd0), n: 1'b1, h: sub_half[4], c: sub_diff[8]};
        if (op == OP_CP) begin
          r8          = 8'd0;
          res.written = 1'b0;
        end
      end
      OP_AND: begin
        r8        = a & b;
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      OP_XOR: begin
        r8        = a ^ b;
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_OR: begin
        r8        = a | b;
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_INC: begin
        r8        = inc_val;
        res.flags = '{z: (r8 == 8'd0), n: 1'b0, h: (r8[3:0] == 4'd0), c: cin};
      end
      OP_DEC: begin
        r8        = dec_val;
        res.flags = '{z: (r8 == 8'd0), n: 1'b1, h: (a[3:0] == 4'd0), c: cin};
      end
      OP_RLCA, OP_RLC: begin
        r8        = {a[6:0], a[7]};
        res.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
      end
      OP_RRCA, OP_RRC: begin
        r8        = {a[0], a[7:1]};
        res.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      OP_RLA, OP_RL: begin
        r8        = {a[6:0], cin};
        res.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
      end
      OP_RRA, OP_RR: begin
        r8        = {cin, a[7:1]};
        res.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      OP_SLA: begin
        r8        = {a[6:0], 1'b0};
        res.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
      end
      OP_SRA: begin
        r8        = {a[7], a[7:1]};
        res.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      OP_SWAP: begin
        r8        = {a[3:0], a[7:4]};
        res.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_SRL: begin
        r8        = {1'b0, a[7:1]};
        res.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      OP_DAA: begin
        r8        = daa_val;
        res.flags = '{z: (r8 == 8'd0), n: f.n, h: 1'b0, c: daa_carry};
      end
      OP_CPL: begin
        r8        = ~a;
        res.flags = '{z: f.z, n: 1'b1, h: 1'b1, c: f.c};
      end
      OP_SCF: begin
        res.written = 1'b0;
        res.flags   = '{z: f.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      OP_CCF: begin
        res.written = 1'b0;
        res.flags   = '{z: f.z, n: 1'b0, h: 1'b0, c: ~cin};
      end
      OP_BIT: begin
        res.written = 1'b0;
        res.flags   = '{z: ~a[req.bit_index], n: 1'b0, h: 1'b1, c: cin};
      end
      OP_RES: begin
        r8 = a & ~bit_mask;
      end
      OP_SET: begin
        r8 = a | bit_mask;
      end
      OP_ADD16: begin
        res.flags = '{z: f.z, n: 1'b0, h: w_half[12], c: w_sum[16]};
      end
      OP_ADD_SP: begin
        res.flags = '{z: 1'b0, n: 1'b0, h: sp_half[4], c: sp_low[8]};
      end
      default: begin
        res.written = 1'b0;
      end
    endcase

    // prefixed rotates and shifts take zero from the result
    case (op)
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
        res.flags.z = (r8 == 8'd0);
      end
      default: begin
      end
    endcase

    case (op)
      OP_ADD16:   res.result = w_sum[15:0];
      OP_ADD_SP:  res.result = sp_sum;
      default:    res.result = {8'd0, r8};
    endcase
  end

endmodule

`default_nettype wire

/* rtl/byte_alu_with_bcd_flags_core.sv */
`default_nettype none

// channel   handshake              payload
// input     in_valid / in_ready    operation operand_a operand_b wide_a wide_b bit_index flags_in
// output    out_valid / out_ready  result result_written flags_out
//
// one transaction per cycle sustained while out_ready holds; input and result registers lie between input and output
// input register feeds one combinational alu pass into the result register
// an output stall holds the result and the input register can still take one transaction
// rst clears both valid bits; payload registers are not reset

module byte_alu_with_bcd_flags_core
  import bacf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  operation,
  input  wire logic [7:0]  operand_a,
  input  wire logic [7:0]  operand_b,
  input  wire logic [15:0] wide_a,
  input  wire logic [15:0] wide_b,
  input  wire logic [2:0]  bit_index,
  input  wire logic [3:0]  flags_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      result,
  output logic             result_written,
  output logic [3:0]       flags_out
);

  logic     req_valid;
  alu_req_t req;
  logic     res_valid;
  alu_res_t res;
  alu_res_t alu_out;
  logic     res_ready;

  assign res_ready = ~res_valid | out_ready;
  assign in_ready  = ~req_valid | res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        req_valid <= in_valid;
      end
      if (res_ready) begin
        res_valid <= req_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= '{operation: operation, operand_a: operand_a, operand_b: operand_b,
               wide_a: wide_a, wide_b: wide_b, bit_index: bit_index,
               flags: flags_t'(flags_in)};
    end
    if (req_valid && res_ready) begin
      res <= alu_out;
    end
  end

  bacf_alu u_alu (
    .req (req),
    .res (alu_out)
  );

  assign out_valid      = res_valid;
  assign result         = res.result;
  assign result_written = res.written;
  assign flags_out      = res.flags;

endmodule

`default_nettype wire
